/* hdl/fifo_queue_with_max_unit_macros.svh */
// ----------------------------------------------------------------------------
// fifo_queue_with_max_unit_macros
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_MAX_UNIT_MACROS_SVH
`define FIFO_QUEUE_WITH_MAX_UNIT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define FQM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqm assertion failed");

// Next-cycle implication, masked during reset.
`define FQM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqm assertion failed");

`endif

/* hdl/fqm_pkg.sv */
// ----------------------------------------------------------------------------
// fqm_pkg
// Types, codes and sizing for the max-reporting queue.
// ----------------------------------------------------------------------------
package fqm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int COUNT_W     = 5;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic               action;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic               max_valid;
        logic signed [31:0] max_value;
    } out_t;

    // Decoded command handed from front to back.
    typedef struct packed {
        logic               is_deq;
        logic signed [31:0] value;
    } cmd_t;

endpackage

/* hdl/fqm_front.sv */
// ----------------------------------------------------------------------------
// fqm_front
// Two-entry input queue; decodes each transaction into a command.
// ----------------------------------------------------------------------------
module fqm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fqm_pkg::in_t  item,
    output logic          full,
    output logic          cmd_valid,
    output fqm_pkg::cmd_t cmd,
    input  logic          cmd_take
);
    import fqm_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_en, rd_en;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg].is_deq <= (item.action == ACT_DEQ);
            slot_reg[wr_ptr_reg].value  <= item.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* hdl/fqm_back.sv */
// ----------------------------------------------------------------------------
// fqm_back
// Ring storage, pointer update and the serial scan for the greatest entry.
// ----------------------------------------------------------------------------
module fqm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  fqm_pkg::cmd_t cmd,
    output logic          cmd_take,
    input  logic          rq_full,
    output logic          rq_push,
    output fqm_pkg::out_t rq_data
);
    import fqm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    logic [31:0] mem [QUEUE_DEPTH];
    logic [31:0] rd_data_reg;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic [CNT_W-1:0]   cmp_reg, cmp_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               first_reg, first_next;
    logic signed [31:0] best_reg, best_next;
    logic [1:0]         status_reg, status_next;
    logic               wr_en, rd_en;
    logic signed [31:0] cand;

    assign cand = signed'(rd_data_reg);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        rd_ptr_next = rd_ptr_reg;
        issue_next  = issue_reg;
        cmp_next    = cmp_reg;
        first_next  = first_reg;
        best_next   = best_reg;
        status_next = status_reg;
        rd_vld_next = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        cmd_take    = 1'b0;
        rq_push     = 1'b0;
        rq_data     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !rq_full)
                begin
                    cmd_take    = 1'b1;
                    status_next = STATUS_DONE;
                    if (!cmd.is_deq)
                    begin
                        if (fill_reg == FULL_CNT)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            tail_next = ring_next(tail_reg);
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else if (fill_reg == CNT_W'(1))
                        begin
                            // queue drains: both pointers return to slot zero
                            head_next = '0;
                            tail_next = '0;
                            fill_next = '0;
                        end
                        else
                        begin
                            head_next = ring_next(head_reg);
                            fill_next = fill_reg - CNT_W'(1);
                        end
                    end

                    if (fill_next == '0)
                    begin
                        rq_push           = 1'b1;
                        rq_data.status    = status_next;
                        rq_data.count     = '0;
                        rq_data.max_valid = 1'b0;
                        rq_data.max_value = '0;
                    end
                    else
                    begin
                        state_next  = ST_SCAN;
                        rd_ptr_next = head_next;
                        issue_next  = fill_next;
                        cmp_next    = fill_next;
                        first_next  = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg != '0)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_ptr_next = ring_next(rd_ptr_reg);
                    issue_next  = issue_reg - CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (first_reg || (best_reg < cand))
                    begin
                        best_next = cand;
                    end
                    first_next = 1'b0;
                    cmp_next   = cmp_reg - CNT_W'(1);
                    if (cmp_reg == CNT_W'(1))
                    begin
                        rq_push           = 1'b1;
                        rq_data.status    = status_reg;
                        rq_data.count     = COUNT_W'(fill_reg);
                        rq_data.max_valid = 1'b1;
                        rq_data.max_value = best_next;
                        state_next        = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg   <= best_next;
        status_reg <= status_next;
        rd_ptr_reg <= rd_ptr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            issue_reg  <= '0;
            cmp_reg    <= '0;
            rd_vld_reg <= 1'b0;
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            issue_reg  <= issue_next;
            cmp_reg    <= cmp_next;
            rd_vld_reg <= rd_vld_next;
            first_reg  <= first_next;
        end
    end

endmodule

/* hdl/fqm_rslt.sv */
// ----------------------------------------------------------------------------
// fqm_rslt
// Two-entry result queue between the back end and the consumer.
// ----------------------------------------------------------------------------
module fqm_rslt (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rq_push,
    input  fqm_pkg::out_t rq_data,
    output logic          rq_full,
    output logic          empty,
    input  logic          pop,
    output fqm_pkg::out_t result
);
    import fqm_pkg::*;

    out_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_en, rd_en;

    assign rq_full = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign result  = slot_reg[rd_ptr_reg];
    assign wr_en   = rq_push && !rq_full;
    assign rd_en   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= rq_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* hdl/fifo_queue_with_max_unit.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_max_unit
// Bounded FIFO of signed 32-bit values that reports its greatest entry.
// ----------------------------------------------------------------------------
// Input channel: push/full. Each transaction either enqueues item.value
// (action 0) or drops the oldest entry (action 1). A two-entry input queue
// keeps taking transactions while the back end is busy.
// Result channel: empty/pop. One result per input transaction, in order:
// status, count after the operation, and the greatest held value.
// Timing: an operation that leaves the queue empty is answered from the idle
// state; otherwise the back end scans the N entries held afterward, and the
// scan reads one ring entry per cycle through the single RAM read port
// and does one signed compare per cycle. The back end takes a new command
// only after it has pushed the result of the one before.
// Reset: pointers and counts clear, the queue is empty; the ring RAM is not
// cleared and needs no clearing pass.
// Stall: when pop is held low the two-entry result queue fills, the back end
// waits, then the input queue fills and full rises.
// ----------------------------------------------------------------------------
module fifo_queue_with_max_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fqm_pkg::in_t  item,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output fqm_pkg::out_t result
);
    import fqm_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;
    logic rq_full;
    logic rq_push;
    out_t rq_data;

    fqm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    fqm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .rq_full   (rq_full),
        .rq_push   (rq_push),
        .rq_data   (rq_data)
    );

    fqm_rslt u_rslt (
        .clk     (clk),
        .rst_n   (rst_n),
        .rq_push (rq_push),
        .rq_data (rq_data),
        .rq_full (rq_full),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

/* hdl/fqm_checker.sv */
// ----------------------------------------------------------------------------
// fqm_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_max_unit_macros.svh"

module fqm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          push,
    input fqm_pkg::in_t  item,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input fqm_pkg::out_t result
);
    import fqm_pkg::*;

    logic res_seen;
    logic in_seen;

    assign res_seen = !empty;
    assign in_seen  = push && !full && (item.action == ACT_DEQ || item.action == ACT_ENQ);

    // an empty queue reports no max and a zero value
    `FQM_ASSERT_IMPL(a_empty_max, clk, rst_n, res_seen && !result.max_valid, (result.max_value == 32'sd0) && (result.count == '0))

    // a failed dequeue only happens on an empty queue
    `FQM_ASSERT_IMPL(a_deq_fail, clk, rst_n, res_seen && (result.status == STATUS_EMPTY), (result.count == '0) && !result.max_valid)

    // a rejected enqueue only happens on a full queue
    `FQM_ASSERT_IMPL(a_enq_fail, clk, rst_n, res_seen && (result.status == STATUS_FULL), result.max_valid && (result.count == COUNT_W'(QUEUE_DEPTH)))

    // a result nobody popped stays put (checked while no input is accepted)
    `FQM_ASSERT_NEXT(a_hold, clk, rst_n, res_seen && !pop && !in_seen, !empty && $stable(result))

endmodule

bind fifo_queue_with_max_unit fqm_checker u_fqm_checker (.*);
